FILE: src/ljam_pkg.sv
// Shared package for the LFSR jump-ahead block: widths, register indexes,
// controller states and the command bundle from controller to datapath.
// No dependencies.
`default_nettype none

package ljam_pkg;

    localparam int STATE_BITS_DEF = 48;   // default LFSR length
    localparam int FIELD_BITS     = 48;   // width of the state fields and of the tap register
    localparam int EXP_BITS       = 6;    // width of the exponent register
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [FIELD_BITS-1:0] TAPS_RESET = 48'hCE00_44C1_01CD;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_JUMP_EXPONENT = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_FEEDBACK_TAPS = 2'd1;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SQUARE,
        ST_COMMIT,
        ST_READY
    } ljam_state_t;

    typedef struct packed {
        logic load;      // load the one-step matrix into both banks
        logic step;      // compute one product row, shift the row line
        logic commit;    // copy the finished product into the matrix
        logic taps_we;   // write the tap register from the config data
    } ljam_cmd_t;

endpackage

`default_nettype wire

FILE: src/lfsr_jump_ahead_matrix_top.sv
// Latency: an item accepted at one edge shows on the output from the next cycle.
// Throughput: one item per cycle once the jump matrix is built, while out_ready is high.
// Rebuild: after reset and after every config write the matrix is rebuilt by
// loading the one-step matrix and squaring it E times (E = jump exponent), one
// product row per cycle; in_ready stays low meanwhile.
// Reset: asynchronous, active low, on control, tap and valid registers only.
`default_nettype none

module lfsr_jump_ahead_matrix_top #(
    parameter int STATE_BITS = ljam_pkg::STATE_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [ljam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [ljam_pkg::FIELD_BITS-1:0]      cfg_data,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire  [STATE_BITS-1:0]                current_state,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [STATE_BITS-1:0]                advanced_state
);

    ljam_pkg::ljam_cmd_t                    cmd;
    logic                                   matrix_ready;
    logic [STATE_BITS-1:0][STATE_BITS-1:0]  matrix;

    ljam_ctrl #(
        .STATE_BITS (STATE_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .matrix_ready (matrix_ready)
    );

    ljam_dp #(
        .STATE_BITS (STATE_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .cfg_data (cfg_data),
        .matrix   (matrix)
    );

    ljam_eval #(
        .STATE_BITS (STATE_BITS)
    ) u_eval (
        .clk            (clk),
        .rst_n          (rst_n),
        .matrix_ready   (matrix_ready),
        .matrix         (matrix),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .current_state  (current_state),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .advanced_state (advanced_state)
    );

endmodule

`default_nettype wire

FILE: src/ljam_ctrl.sv
// Controller for the LFSR jump-ahead block: config register decode, exponent
// register, and the state machine that sequences the matrix rebuild.
// Depends on ljam_pkg.
`default_nettype none

module ljam_ctrl #(
    parameter int STATE_BITS = ljam_pkg::STATE_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [ljam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire  [ljam_pkg::FIELD_BITS-1:0]      cfg_data,
    output ljam_pkg::ljam_cmd_t                  cmd,
    output logic                                 matrix_ready
);

    localparam int ROW_BITS = (STATE_BITS > 1) ? $clog2(STATE_BITS) : 1;
    localparam logic [ROW_BITS-1:0] LAST_ROW = ROW_BITS'(STATE_BITS - 1);

    ljam_pkg::ljam_state_t                 state_reg, state_next;
    logic [ROW_BITS-1:0]                   row_cnt_reg, row_cnt_next;
    logic [ljam_pkg::EXP_BITS-1:0]         sq_cnt_reg, sq_cnt_next;
    logic [ljam_pkg::EXP_BITS-1:0]         exp_reg, exp_next;
    logic                                  cfg_fire;
    logic                                  exp_we;
    logic                                  taps_we;

    assign cfg_ready    = 1'b1;
    assign cfg_fire     = cfg_valid && cfg_ready;
    assign matrix_ready = (state_reg == ljam_pkg::ST_READY);

    // Register decode; an unknown index writes nothing but still forces a rebuild
    always_comb
    begin
        exp_we  = 1'b0;
        taps_we = 1'b0;
        unique case (cfg_index)
            ljam_pkg::CFG_JUMP_EXPONENT: exp_we  = cfg_fire;
            ljam_pkg::CFG_FEEDBACK_TAPS: taps_we = cfg_fire;
            default:
            begin
                exp_we  = 1'b0;
                taps_we = 1'b0;
            end
        endcase
    end

    assign exp_next = exp_we ? cfg_data[ljam_pkg::EXP_BITS-1:0] : exp_reg;

    always_comb
    begin
        state_next   = state_reg;
        row_cnt_next = row_cnt_reg;
        sq_cnt_next  = sq_cnt_reg;
        cmd.load     = 1'b0;
        cmd.step     = 1'b0;
        cmd.commit   = 1'b0;
        cmd.taps_we  = taps_we;
        unique case (state_reg)
            ljam_pkg::ST_LOAD:
            begin
                cmd.load     = 1'b1;
                row_cnt_next = '0;
                sq_cnt_next  = '0;
                state_next   = (exp_reg == '0) ? ljam_pkg::ST_READY : ljam_pkg::ST_SQUARE;
            end
            ljam_pkg::ST_SQUARE:
            begin
                cmd.step     = 1'b1;
                row_cnt_next = row_cnt_reg + 1'b1;
                if (row_cnt_reg == LAST_ROW)
                begin
                    state_next = ljam_pkg::ST_COMMIT;
                end
            end
            ljam_pkg::ST_COMMIT:
            begin
                cmd.commit   = 1'b1;
                row_cnt_next = '0;
                sq_cnt_next  = sq_cnt_reg + 1'b1;
                if (sq_cnt_reg == exp_reg - 1'b1)
                begin
                    state_next = ljam_pkg::ST_READY;
                end
                else
                begin
                    state_next = ljam_pkg::ST_SQUARE;
                end
            end
            ljam_pkg::ST_READY:
            begin
                state_next = ljam_pkg::ST_READY;
            end
            default:
            begin
                state_next = ljam_pkg::ST_LOAD;
            end
        endcase
        // any config write restarts the rebuild from the new registers
        if (cfg_fire)
        begin
            state_next = ljam_pkg::ST_LOAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ljam_pkg::ST_LOAD;
            row_cnt_reg <= '0;
            sq_cnt_reg  <= '0;
            exp_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            row_cnt_reg <= row_cnt_next;
            sq_cnt_reg  <= sq_cnt_next;
            exp_reg     <= exp_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/ljam_dp.sv
// Matrix datapath: tap register, jump matrix and the row line used while
// squaring, one product row per cycle. Depends on ljam_pkg.
`default_nettype none

module ljam_dp #(
    parameter int STATE_BITS = ljam_pkg::STATE_BITS_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  ljam_pkg::ljam_cmd_t                    cmd,
    input  wire  [ljam_pkg::FIELD_BITS-1:0]        cfg_data,
    output logic [STATE_BITS-1:0][STATE_BITS-1:0]  matrix
);

    localparam int FB = ljam_pkg::FIELD_BITS;

    logic [FB-1:0]                          taps_reg;
    logic [STATE_BITS-1:0]                  taps_row;
    logic [STATE_BITS-1:0][STATE_BITS-1:0]  step_matrix;
    logic [STATE_BITS-1:0][STATE_BITS-1:0]  matrix_reg;
    logic [STATE_BITS-1:0][STATE_BITS-1:0]  line_reg;
    logic [STATE_BITS-1:0]                  prod_row;

    // Tap bits beyond the register width read as zero
    for (genvar b = 0; b < STATE_BITS; b++)
    begin : g_taps
        if (b < FB)
        begin : g_in
            assign taps_row[b] = taps_reg[b];
        end
        else
        begin : g_out
            assign taps_row[b] = 1'b0;
        end
    end

    // One LFSR step: row i picks bit i+1, the top row picks the taps
    for (genvar r = 0; r < STATE_BITS; r++)
    begin : g_step
        if (r < STATE_BITS - 1)
        begin : g_shift
            assign step_matrix[r] = {{(STATE_BITS-1){1'b0}}, 1'b1} << (r + 1);
        end
        else
        begin : g_fb
            assign step_matrix[r] = taps_row;
        end
    end

    // Product row for the selector at the bottom of the line
    always_comb
    begin
        prod_row = '0;
        for (int j = 0; j < STATE_BITS; j++)
        begin
            prod_row = prod_row ^ (matrix_reg[j] & {STATE_BITS{line_reg[0][j]}});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= ljam_pkg::TAPS_RESET;
        end
        else if (cmd.taps_we)
        begin
            taps_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            matrix_reg <= step_matrix;
            line_reg   <= step_matrix;
        end
        else
        begin
            if (cmd.step)
            begin
                // drop the used selector, push the new row in at the top
                line_reg <= {prod_row, line_reg[STATE_BITS-1:1]};
            end
            if (cmd.commit)
            begin
                matrix_reg <= line_reg;
            end
        end
    end

    assign matrix = matrix_reg;

endmodule

`default_nettype wire

FILE: src/ljam_eval.sv
// Evaluation stage: one parity tree per output bit over the jump matrix,
// followed by the output register. Depends on ljam_pkg.
`default_nettype none

module ljam_eval #(
    parameter int STATE_BITS = ljam_pkg::STATE_BITS_DEF
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire                                    matrix_ready,
    input  wire  [STATE_BITS-1:0][STATE_BITS-1:0]  matrix,
    input  wire                                    in_valid,
    output logic                                   in_ready,
    input  wire  [STATE_BITS-1:0]                  current_state,
    output logic                                   out_valid,
    input  wire                                    out_ready,
    output logic [STATE_BITS-1:0]                  advanced_state
);

    localparam int FB = ljam_pkg::FIELD_BITS;

    logic [STATE_BITS-1:0] state_in;
    logic [STATE_BITS-1:0] result_next;
    logic [STATE_BITS-1:0] advanced_state_reg;
    logic                  out_valid_reg;
    logic                  in_fire;

    for (genvar b = 0; b < STATE_BITS; b++)
    begin : g_bit
        if (b < FB)
        begin : g_in
            assign state_in[b]    = current_state[b];
            assign result_next[b] = ^(matrix[b] & state_in);
        end
        else
        begin : g_out
            assign state_in[b]    = 1'b0;
            assign result_next[b] = 1'b0;
        end
    end

    assign in_ready = matrix_ready && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            advanced_state_reg <= result_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign advanced_state = advanced_state_reg;

endmodule

`default_nettype wire

FILE: dv/tb_lfsr_jump_ahead_matrix_top.sv
// Self-checking testbench for lfsr_jump_ahead_matrix_top: predicts each advanced state
// from its own GF(2) jump matrix and checks it against the output stream.
// Depends on ljam_pkg and the block's RTL only.
`timescale 1ns / 100ps

module tb_lfsr_jump_ahead_matrix_top;

    import ljam_pkg::*;

    localparam int WIDTH = STATE_BITS_DEF;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_TWO   = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_THREE = 2'd3;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT      = 200000;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_JUMP_EXPONENT;
    logic [FIELD_BITS-1:0]     cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [WIDTH-1:0]          current_state = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [WIDTH-1:0]          advanced_state;

    // predictor state
    logic [EXP_BITS-1:0] model_exponent;
    logic [WIDTH-1:0]    model_taps;
    logic [WIDTH-1:0]    jump_rows [WIDTH];

    logic [WIDTH-1:0] pending_states [$];
    logic [WIDTH-1:0] expected_states [$];

    bit idle_bursts = 1'b1;
    int send_gap = 0;
    int recv_stall = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int mismatch_count = 0;

    lfsr_jump_ahead_matrix_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .current_state  (current_state),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .advanced_state (advanced_state)
    );

    always #5 clk = ~clk;

    // One-step matrix from the taps, then squared once per exponent count.
    function automatic void rebuild_jump_rows();
        logic [WIDTH-1:0] product [WIDTH];
        logic [WIDTH-1:0] acc;
        for (int i = 0; i < WIDTH - 1; i++)
            jump_rows[i] = {{(WIDTH-1){1'b0}}, 1'b1} << (i + 1);
        jump_rows[WIDTH-1] = model_taps;
        for (int n = 0; n < int'(model_exponent); n++)
        begin
            for (int i = 0; i < WIDTH; i++)
            begin
                acc = '0;
                for (int j = 0; j < WIDTH; j++)
                    if (jump_rows[i][j])
                        acc ^= jump_rows[j];
                product[i] = acc;
            end
            for (int i = 0; i < WIDTH; i++)
                jump_rows[i] = product[i];
        end
    endfunction

    function automatic logic [WIDTH-1:0] jump_state(input logic [WIDTH-1:0] s);
        logic [WIDTH-1:0] r;
        for (int i = 0; i < WIDTH; i++)
            r[i] = ^(jump_rows[i] & s);
        return r;
    endfunction

    function automatic logic [WIDTH-1:0] random_word();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[WIDTH-1:0];
    endfunction

    function automatic logic [WIDTH-1:0] random_state();
        logic [WIDTH-1:0] one_hot;
        one_hot = {{(WIDTH-1){1'b0}}, 1'b1} << $urandom_range(0, WIDTH - 1);
        case ($urandom_range(0, 9))
            0: return one_hot;
            1: return ~one_hot;
            2: return random_word() & random_word() & random_word();
            3: return '1;
            default: return random_word();
        endcase
    endfunction

    // Sender: present pending items, hold each until accepted.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                expected_states.push_back(jump_state(current_state));
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap--;
                end
                else if (pending_states.size() > 0)
                begin
                    current_state <= pending_states.pop_front();
                    in_valid <= 1'b1;
                    if (idle_bursts && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 9);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: check each accepted item, stall in bursts or on request.
    always @(posedge clk)
    begin
        logic [WIDTH-1:0] want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    $error("advanced_state: no item expected, got %h", advanced_state);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (advanced_state !== want)
                    begin
                        $error("advanced_state: expected %h, got %h", want, advanced_state);
                        mismatch_count++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served = hold_requests;
                recv_stall = LONG_HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else if (idle_bursts && $urandom_range(0, 6) == 0)
            begin
                recv_stall = $urandom_range(0, 8);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    task automatic write_register(input logic [CFG_INDEX_BITS-1:0] idx,
                                  input logic [FIELD_BITS-1:0] value);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_JUMP_EXPONENT: model_exponent = value[EXP_BITS-1:0];
            CFG_FEEDBACK_TAPS: model_taps = value[WIDTH-1:0];
            default: ;
        endcase
        rebuild_jump_rows();
    endtask

    // Wait until every item is sent and every result is back.
    task automatic wait_drained();
        int cycles;
        cycles = 0;
        @(negedge clk);
        while ((pending_states.size() > 0 || in_valid || send_gap > 0
                || expected_states.size() > 0) && cycles < DRAIN_LIMIT)
        begin
            @(negedge clk);
            cycles++;
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_states(input int count);
        @(negedge clk);
        repeat (count) pending_states.push_back(random_state());
    endtask

    task automatic random_settings();
        logic [FIELD_BITS-1:0] value;
        value = random_word();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: value[EXP_BITS-1:0] = EXP_BITS'($urandom_range(0, 6));
            7, 8: value[EXP_BITS-1:0] = EXP_BITS'($urandom_range(7, 48));
            default: value[EXP_BITS-1:0] = EXP_BITS'($urandom_range(49, 63));
        endcase
        write_register(CFG_JUMP_EXPONENT, value);
        if ($urandom_range(0, 3) != 0)
            write_register(CFG_FEEDBACK_TAPS, random_state());
        if ($urandom_range(0, 5) == 0)
            write_register($urandom_range(0, 1) ? CFG_SPARE_TWO : CFG_SPARE_THREE,
                           random_word());
    endtask

    initial
    begin
        model_exponent = '0;
        model_taps = TAPS_RESET[WIDTH-1:0];
        rebuild_jump_rows();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: extremes of the state
        @(negedge clk);
        pending_states.push_back('0);
        pending_states.push_back('1);
        pending_states.push_back({{(WIDTH-1){1'b0}}, 1'b1});
        pending_states.push_back({1'b1, {(WIDTH-1){1'b0}}});
        pending_states.push_back({(WIDTH/2){2'b10}});
        pending_states.push_back({(WIDTH/2){2'b01}});
        wait_drained();

        // largest nominal exponent, every tap set
        write_register(CFG_JUMP_EXPONENT, FIELD_BITS'(48));
        write_register(CFG_FEEDBACK_TAPS, '1);
        @(negedge clk);
        pending_states.push_back('1);
        pending_states.push_back({{(WIDTH-1){1'b0}}, 1'b1});
        pending_states.push_back({(WIDTH/2){2'b10}});
        wait_drained();

        // exponent beyond the state width, upper data bits ignored
        write_register(CFG_JUMP_EXPONENT, '1);
        @(negedge clk);
        pending_states.push_back({1'b1, {(WIDTH-1){1'b0}}});
        pending_states.push_back({(WIDTH/2){2'b01}});
        pending_states.push_back('1);
        wait_drained();

        // no taps: pure shift
        write_register(CFG_FEEDBACK_TAPS, '0);
        write_register(CFG_JUMP_EXPONENT, FIELD_BITS'(1));
        @(negedge clk);
        pending_states.push_back('1);
        pending_states.push_back({1'b1, {(WIDTH-1){1'b0}}});
        wait_drained();

        // writes to unused indexes leave the settings alone
        write_register(CFG_SPARE_TWO, '1);
        @(negedge clk);
        pending_states.push_back({(WIDTH/2){2'b10}});
        wait_drained();
        write_register(CFG_SPARE_THREE, random_word());
        write_register(CFG_FEEDBACK_TAPS, TAPS_RESET);
        write_register(CFG_JUMP_EXPONENT, '0);
        @(negedge clk);
        pending_states.push_back({(WIDTH/2){2'b01}});
        pending_states.push_back('1);
        wait_drained();

        for (int phase = 0; phase < 8; phase++)
        begin
            random_settings();
            if (phase == 7)
            begin
                @(negedge clk);
                idle_bursts = 1'b0;
            end
            queue_states(250);
            if (phase == 2)
                hold_requests++;
            wait_drained();
        end

        if (expected_states.size() > 0)
        begin
            $error("advanced_state: %0d expected items never arrived",
                   expected_states.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("tb_lfsr_jump_ahead_matrix_top: clean");
        else
            $display("tb_lfsr_jump_ahead_matrix_top: errors");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_lfsr_jump_ahead_matrix_top: errors");
        $finish;
    end

endmodule
